/* hw/rtl/dcms_pkg.sv */
package dcms_pkg;

  localparam int DEPTH_W     = 16;
  localparam int ROW_W       = 10;
  localparam int COL_W       = 10;
  localparam int WIDTH_W     = 11;
  localparam int DSL_W       = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef logic [DEPTH_W-1:0]  depth_t;
  typedef logic [ROW_W-1:0]    row_t;
  typedef logic [COL_W-1:0]    col_t;
  typedef logic [WIDTH_W-1:0]  width_t;
  typedef logic [DSL_W-1:0]    dsl_t;
  typedef logic [OQ_PTR_W-1:0] oq_ptr_t;
  typedef logic [OQ_CNT_W-1:0] oq_cnt_t;
  typedef logic [OQ_CNT_W:0]   occ_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_DEPTH  = 3'd0,
    REG_MAX_DEPTH  = 3'd1,
    REG_BAND_FIRST = 3'd2,
    REG_BAND_LAST  = 3'd3,
    REG_IMG_WIDTH  = 3'd4,
    REG_DSL        = 3'd5
  } cfg_reg_t;

  localparam depth_t RST_MIN_DEPTH  = 16'd200;
  localparam depth_t RST_MAX_DEPTH  = 16'd5000;
  localparam row_t   RST_BAND_FIRST = 10'd0;
  localparam row_t   RST_BAND_LAST  = 10'd1023;
  localparam width_t RST_IMG_WIDTH  = 11'd640;
  localparam dsl_t   RST_DSL        = 2'd1;

  typedef struct packed {
    logic   hit;
    depth_t min;
  } entry_t;

  typedef struct packed {
    col_t   scan_index;
    depth_t range_mm;
    logic   no_return;
  } result_t;

endpackage

/* hw/rtl/dcms_pixel_if.sv */
interface dcms_pixel_if;
  logic                  valid;
  logic                  ready;
  dcms_pkg::depth_t      depth_mm;
  dcms_pkg::row_t        pixel_row;
  dcms_pkg::col_t        pixel_col;

  modport source (output valid, output depth_mm, output pixel_row, output pixel_col,
                  input ready);
  modport sink (input valid, input depth_mm, input pixel_row, input pixel_col,
                output ready);
endinterface

/* hw/rtl/dcms_scan_if.sv */
interface dcms_scan_if;
  logic             valid;
  logic             ready;
  dcms_pkg::col_t   scan_index;
  dcms_pkg::depth_t range_mm;
  logic             no_return;

  modport source (output valid, output scan_index, output range_mm, output no_return,
                  input ready);
  modport sink (input valid, input scan_index, input range_mm, input no_return,
                output ready);
endinterface

/* hw/rtl/dcms_cfg_if.sv */
interface dcms_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [dcms_pkg::CFG_INDEX_W-1:0]     index;
  logic [dcms_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/depth_column_min_scan_unit.sv */
// Column-minimum depth scan. One depth pixel per clock enters on the pixel channel while
// ready is high; pixels of kept columns inside the row band update a per-column minimum
// held in a single-port-read, single-port-write column store, and the pixel on the last band
// row of a kept column produces one scan transaction. The datapath is a three-stage
// pipeline (decode, store read and compare, result) that never stalls; back-to-back pixels of
// the same column are forwarded around the store. Results wait in an eight-entry output queue,
// and ready drops only when the queue plus the pixels in flight reach eight, so with the scan
// side ready the sustained rate is one pixel per clock. The column store needs no clearing
// after reset: each column entry restarts at the first band row. Configuration writes are
// taken at any time and belong between frames.
module depth_column_min_scan_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input logic         clk,
  input logic         rst,
  dcms_pixel_if.sink  pixel,
  dcms_scan_if.source scan,
  dcms_cfg_if.sink    cfg
);

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  typedef logic [ADDR_W-1:0] addr_t;

  // configuration registers
  dcms_pkg::depth_t min_depth_mm;
  dcms_pkg::depth_t max_depth_mm;
  dcms_pkg::row_t   band_first_row;
  dcms_pkg::row_t   band_last_row;
  dcms_pkg::width_t image_width;
  dcms_pkg::dsl_t   downsample_log2;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_depth_mm    <= dcms_pkg::RST_MIN_DEPTH;
      max_depth_mm    <= dcms_pkg::RST_MAX_DEPTH;
      band_first_row  <= dcms_pkg::RST_BAND_FIRST;
      band_last_row   <= dcms_pkg::RST_BAND_LAST;
      image_width     <= dcms_pkg::RST_IMG_WIDTH;
      downsample_log2 <= dcms_pkg::RST_DSL;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        dcms_pkg::REG_MIN_DEPTH:  min_depth_mm    <= cfg.data[dcms_pkg::DEPTH_W-1:0];
        dcms_pkg::REG_MAX_DEPTH:  max_depth_mm    <= cfg.data[dcms_pkg::DEPTH_W-1:0];
        dcms_pkg::REG_BAND_FIRST: band_first_row  <= cfg.data[dcms_pkg::ROW_W-1:0];
        dcms_pkg::REG_BAND_LAST:  band_last_row   <= cfg.data[dcms_pkg::ROW_W-1:0];
        dcms_pkg::REG_IMG_WIDTH:  image_width     <= cfg.data[dcms_pkg::WIDTH_W-1:0];
        dcms_pkg::REG_DSL:        downsample_log2 <= cfg.data[dcms_pkg::DSL_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: registered pixel
  logic             in_accept;
  logic             s1_valid;
  dcms_pkg::depth_t s1_depth;
  dcms_pkg::row_t   s1_row;
  dcms_pkg::col_t   s1_col;

  assign in_accept = pixel.valid & pixel.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_depth <= pixel.depth_mm;
    s1_row   <= pixel.pixel_row;
    s1_col   <= pixel.pixel_col;
  end

  // stage 1 decode
  dcms_pkg::col_t   step_mask;
  dcms_pkg::col_t   s1_pos;
  dcms_pkg::width_t ranges;
  logic             s1_col_keep;
  logic             s1_row_keep;
  logic             s1_hit;
  logic             s1_depth_ok;
  dcms_pkg::col_t   s1_scan_index;
  addr_t            s1_addr;

  always_comb begin
    step_mask     = (dcms_pkg::col_t'(1) << downsample_log2) - dcms_pkg::col_t'(1);
    s1_pos        = s1_col >> downsample_log2;
    ranges        = image_width >> downsample_log2;
    s1_col_keep   = ((s1_col & step_mask) == '0) &&
                    (dcms_pkg::width_t'(s1_pos) < ranges) &&
                    (int'(s1_pos) < MAX_WIDTH);
    s1_row_keep   = (int'(s1_row) < MAX_HEIGHT) &&
                    (s1_row >= band_first_row) && (s1_row <= band_last_row);
    s1_hit        = s1_valid && s1_col_keep && s1_row_keep;
    s1_depth_ok   = (s1_depth != '0) && (s1_depth >= min_depth_mm) &&
                    (s1_depth <= max_depth_mm);
    s1_scan_index = dcms_pkg::col_t'(ranges - dcms_pkg::width_t'(1) -
                                     dcms_pkg::width_t'(s1_pos));
    s1_addr       = addr_t'(s1_pos);
  end

  // column store
  dcms_pkg::entry_t col_store [MAX_WIDTH];
  dcms_pkg::entry_t rd_entry;

  // stage 2: store read data and compare
  logic             s2_valid;
  addr_t            s2_addr;
  logic             s2_first;
  logic             s2_last;
  logic             s2_depth_ok;
  dcms_pkg::depth_t s2_depth;
  dcms_pkg::col_t   s2_scan_index;
  dcms_pkg::entry_t s2_base;
  dcms_pkg::entry_t s2_entry;

  // stage 3: result
  logic             s3_valid;
  addr_t            s3_addr;
  logic             s3_emit;
  dcms_pkg::col_t   s3_scan_index;
  dcms_pkg::entry_t s3_entry;

  always_ff @(posedge clk) begin
    rd_entry <= col_store[s1_addr];
    if (s2_valid) begin
      col_store[s2_addr] <= s2_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_hit;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr       <= s1_addr;
    s2_first      <= (s1_row == band_first_row);
    s2_last       <= (s1_row == band_last_row);
    s2_depth_ok   <= s1_depth_ok;
    s2_depth      <= s1_depth;
    s2_scan_index <= s1_scan_index;
  end

  // the item one ahead wrote the store on the same edge this one read it
  always_comb begin
    priority if (s2_first) begin
      s2_base = '0;
    end else if (s3_valid && (s3_addr == s2_addr)) begin
      s2_base = s3_entry;
    end else begin
      s2_base = rd_entry;
    end
    s2_entry = s2_base;
    if (s2_depth_ok && (!s2_base.hit || (s2_depth < s2_base.min))) begin
      s2_entry.hit = 1'b1;
      s2_entry.min = s2_depth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_addr       <= s2_addr;
    s3_emit       <= s2_last;
    s3_scan_index <= s2_scan_index;
    s3_entry      <= s2_entry;
  end

  dcms_pkg::result_t s3_result;
  logic              s3_push;

  always_comb begin
    s3_result.scan_index = s3_scan_index;
    s3_result.range_mm   = s3_entry.hit ? s3_entry.min : '0;
    s3_result.no_return  = !s3_entry.hit;
    s3_push              = s3_valid && s3_emit;
  end

  // output queue
  dcms_pkg::result_t oq_data;
  dcms_pkg::oq_cnt_t oq_count;
  dcms_pkg::occ_t    occupancy;

  dcms_result_fifo u_oq (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_push),
    .push_data (s3_result),
    .pop_valid (scan.valid),
    .pop_ready (scan.ready),
    .pop_data  (oq_data),
    .count     (oq_count)
  );

  assign scan.scan_index = oq_data.scan_index;
  assign scan.range_mm   = oq_data.range_mm;
  assign scan.no_return  = oq_data.no_return;

  // reserve a queue slot for every pixel in flight
  assign occupancy   = dcms_pkg::occ_t'(oq_count) + dcms_pkg::occ_t'(s1_valid) +
                       dcms_pkg::occ_t'(s2_valid) + dcms_pkg::occ_t'(s3_valid);
  assign pixel.ready = (occupancy < dcms_pkg::occ_t'(dcms_pkg::OQ_DEPTH));

endmodule

/* hw/rtl/dcms_result_fifo.sv */
module dcms_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dcms_pkg::result_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output dcms_pkg::result_t pop_data,
  output dcms_pkg::oq_cnt_t count
);

  dcms_pkg::result_t slot [dcms_pkg::OQ_DEPTH];
  dcms_pkg::oq_ptr_t wr_ptr;
  dcms_pkg::oq_ptr_t rd_ptr;
  logic              pop;

  assign pop_valid = (count != '0);
  assign pop       = pop_valid & pop_ready;
  assign pop_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + dcms_pkg::oq_ptr_t'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + dcms_pkg::oq_ptr_t'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + dcms_pkg::oq_cnt_t'(1);
        2'b01:   count <= count - dcms_pkg::oq_cnt_t'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/dcms_port_checker.sv */
module dcms_port_checker (
  input logic             clk,
  input logic             rst,
  input logic             pix_valid,
  input logic             pix_ready,
  input logic             scan_valid,
  input logic             scan_ready,
  input dcms_pkg::col_t   scan_index,
  input dcms_pkg::depth_t range_mm,
  input logic             no_return
);

  logic pix_accept;

  assign pix_accept = pix_valid & pix_ready;

  // stalled transaction holds
  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    scan_valid && !scan_ready |=>
      scan_valid && $stable(scan_index) && $stable(range_mm) && $stable(no_return))
    else $error("scan transaction changed while stalled");

  a_no_return_zero: assert property (@(posedge clk) disable iff (rst)
    scan_valid && no_return |-> range_mm == '0)
    else $error("no-return transaction with non-zero range");

  a_return_nonzero: assert property (@(posedge clk) disable iff (rst)
    scan_valid && !no_return |-> range_mm != '0)
    else $error("return transaction with zero range");

  // fixed latency from pixel to first queued result
  a_rise_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(scan_valid) |-> $past(pix_accept, 4))
    else $error("scan transaction without matching pixel");

  // pixel side only backs up behind pending results
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> scan_valid)
    else $error("pixel ready low with no pending result");

endmodule

bind depth_column_min_scan_unit dcms_port_checker u_port_checker (
  .clk        (clk),
  .rst        (rst),
  .pix_valid  (pixel.valid),
  .pix_ready  (pixel.ready),
  .scan_valid (scan.valid),
  .scan_ready (scan.ready),
  .scan_index (scan.scan_index),
  .range_mm   (scan.range_mm),
  .no_return  (scan.no_return)
);
